FILE: design/oaht_pkg.sv
// Package for the open-addressing hash table: opcodes, result codes and the
// command and status structs that join the controller and the datapath.
// No dependencies; every other file but oaht_ram imports it.
`default_nettype none

package oaht_pkg;

  // Fixed field widths of the transfer payloads and the register port.
  localparam int KEY_FIELD_W   = 32;
  localparam int HASH_W        = 32;
  localparam int VALUE_FIELD_W = 64;
  localparam int LIMIT_W       = 8;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 3;

  // Register index, taken from address bit 2.
  localparam logic REG_OCC_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // Which value the pending result register takes.
  typedef enum logic [1:0] {
    RES_NONE   = 2'd0,
    RES_ABSENT = 2'd1,
    RES_OK     = 2'd2,
    RES_COMMIT = 2'd3
  } res_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     probe_start;
    logic     probe_run;
    logic     sweep_start;
    logic     sweep_run;
    logic     commit;
    logic     out_load;
    res_sel_e res_sel;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_e op;
    logic    count_zero;
    logic    hash_ready;
    logic    probe_stop;
    logic    sweep_last;
    logic    out_free;
  } dp_stat_t;

endpackage : oaht_pkg

`default_nettype wire

FILE: design/oaht_if.sv
// Valid/ready channel interfaces for the request and response transfers.
// Depends on oaht_pkg for the field widths.
`default_nettype none

interface oaht_req_if;
  import oaht_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic [KEY_FIELD_W-1:0]   key_id;
  logic [HASH_W-1:0]        key_hash;
  logic [VALUE_FIELD_W-1:0] value_in;

  modport source (output valid, opcode, key_id, key_hash, value_in, input ready);
  modport sink   (input valid, opcode, key_id, key_hash, value_in, output ready);
endinterface : oaht_req_if

interface oaht_rsp_if;
  import oaht_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [VALUE_FIELD_W-1:0] value_out;
  logic                     key_was_new;

  modport source (output valid, status, value_out, key_was_new, input ready);
  modport sink   (input valid, status, value_out, key_was_new, output ready);
endinterface : oaht_rsp_if

`default_nettype wire

FILE: design/open_addressing_hash_table_top.sv
// Linear-probing hash table with tombstones; one result per request.
// A request is loaded, its hash reduced to the first probe slot and the slots probed one
// slot a cycle on the read port; the result is then committed and held for transfer.
// The hash reduction is iterative when SLOTS is not a power of two. A clear sweeps every
// slot; a get or delete skips the probe while the occupancy count is zero. One request
// is in work at a time. Reset: clearing pass over the slot state, requests held off.
`default_nettype none

module open_addressing_hash_table_top #(
  parameter int SLOTS      = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  oaht_req_if.sink                            req_i,
  oaht_rsp_if.source                          rsp_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [oaht_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [oaht_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [oaht_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);
  import oaht_pkg::*;

  localparam int LIMIT_RAW   = (SLOTS * 3) / 4;
  localparam int LIMIT_RESET = (LIMIT_RAW > 255) ? 255 : LIMIT_RAW;

  // Occupancy limit register on the APB port.
  logic [LIMIT_W-1:0] limit_q;
  logic               reg_sel;

  assign reg_sel = (paddr[2] == REG_OCC_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_W'(LIMIT_RESET);
    end else if (psel && penable && pwrite && reg_sel) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  oaht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  oaht_datapath #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .opcode_i     (req_i.opcode),
    .key_id_i     (req_i.key_id),
    .key_hash_i   (req_i.key_hash),
    .value_in_i   (req_i.value_in),
    .limit_i      (limit_q),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_status_o (rsp_o.status),
    .rsp_value_o  (rsp_o.value_out),
    .rsp_new_o    (rsp_o.key_was_new)
  );

endmodule : open_addressing_hash_table_top

`default_nettype wire

FILE: design/oaht_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : oaht_ram

`default_nettype wire

FILE: design/oaht_datapath.sv
// Datapath of the hash table: item registers, hash reduction, probe walk,
// slot memories, occupancy count and result registers.
// Depends on oaht_pkg and oaht_ram.
`default_nettype none

module oaht_datapath #(
  parameter int SLOTS      = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [1:0]                        opcode_i,
  input  wire logic [oaht_pkg::KEY_FIELD_W-1:0]  key_id_i,
  input  wire logic [oaht_pkg::HASH_W-1:0]       key_hash_i,
  input  wire logic [oaht_pkg::VALUE_FIELD_W-1:0] value_in_i,
  input  wire logic [oaht_pkg::LIMIT_W-1:0]      limit_i,
  input  wire oaht_pkg::ctrl_cmd_t               cmd_i,
  output oaht_pkg::dp_stat_t                     stat_o,
  input  wire logic                              rsp_ready_i,
  output logic                                   rsp_valid_o,
  output logic [1:0]                             rsp_status_o,
  output logic [oaht_pkg::VALUE_FIELD_W-1:0]     rsp_value_o,
  output logic                                   rsp_new_o
);
  import oaht_pkg::*;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int KW     = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam int VB     = VALUE_BITS;
  localparam int CMP_W  = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;
  localparam bit POW2   = ((1 << IDX_W) == SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // Slot state bits: used and tombstone.
  localparam logic [1:0] META_EMPTY = 2'b00;
  localparam logic [1:0] META_USED  = 2'b10;
  localparam logic [1:0] META_TOMB  = 2'b01;

  // Item registers.
  opcode_e       op_q;
  logic [KW-1:0] key_q;
  logic [VB-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_e'(opcode_i);
      key_q <= key_id_i[KW-1:0];
      val_q <= value_in_i[VB-1:0];
    end
  end

  // Reduction of the hash to the first probe slot.
  logic [IDX_W-1:0] rem_q;
  logic             rem_ready_q;

  if (POW2) begin : g_hash_mask
    // Power-of-two table: the low hash bits are the slot.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_ready_q <= 1'b0;
      end else if (cmd_i.load) begin
        rem_ready_q <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        rem_q <= key_hash_i[IDX_W-1:0];
      end
    end
  end else begin : g_hash_mod
    // Restoring remainder, four hash bits a cycle, most significant first.
    localparam int HBITS = 4;
    localparam int STEPS = HASH_W / HBITS;
    localparam int STEP_W = $clog2(STEPS);
    localparam logic [IDX_W:0] SLOTS_EXT = (IDX_W + 1)'(SLOTS);

    logic [HASH_W-1:0] hsh_q;
    logic [STEP_W-1:0] step_q;
    logic [IDX_W:0]    r_acc;

    always_comb begin
      r_acc = {1'b0, rem_q};
      for (int k = 0; k < HBITS; k++) begin
        r_acc = {r_acc[IDX_W-1:0], hsh_q[HASH_W-1-k]};
        if (r_acc >= SLOTS_EXT) begin
          r_acc = r_acc - SLOTS_EXT;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_ready_q <= 1'b0;
        step_q      <= '0;
      end else if (cmd_i.load) begin
        rem_ready_q <= 1'b0;
        step_q      <= '0;
      end else if (!rem_ready_q) begin
        step_q      <= step_q + STEP_W'(1);
        rem_ready_q <= (step_q == STEP_W'(STEPS - 1));
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        hsh_q <= key_hash_i;
        rem_q <= '0;
      end else if (!rem_ready_q) begin
        hsh_q <= hsh_q << HBITS;
        rem_q <= r_acc[IDX_W-1:0];
      end
    end
  end

  // Slot memories: state bits, and key with value.
  logic             meta_we;
  logic [IDX_W-1:0] meta_waddr;
  logic [1:0]       meta_wdata;
  logic [1:0]       meta_rd;
  logic             kv_we;
  logic [KW+VB-1:0] kv_rd;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] where_q;

  oaht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (rd_addr),
    .rdata_o (meta_rd)
  );

  oaht_ram #(.WIDTH(KW + VB), .DEPTH(SLOTS)) u_kv_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (where_q),
    .wdata_i ({key_q, val_q}),
    .raddr_i (rd_addr),
    .rdata_o (kv_rd)
  );

  // Probe walk: while it runs, the read data belongs to probe_idx_q.
  logic [IDX_W-1:0] probe_idx_q;
  logic [IDX_W-1:0] idx_next;
  logic [IDX_W-1:0] visited_q;
  logic             have_tomb_q;
  logic [IDX_W-1:0] tomb_q;
  logic             slot_used;
  logic             slot_tomb;
  logic             slot_match;
  logic             slot_empty;
  logic             probe_last;
  logic             probe_stop;

  assign idx_next   = (probe_idx_q == LAST_IDX) ? '0 : probe_idx_q + IDX_W'(1);
  assign slot_used  = meta_rd[1];
  assign slot_tomb  = meta_rd[0] & ~meta_rd[1];
  assign slot_match = slot_used && (kv_rd[KW+VB-1:VB] == key_q);
  assign slot_empty = ~meta_rd[1] & ~meta_rd[0];
  assign probe_last = (visited_q == LAST_IDX);
  assign probe_stop = slot_match || slot_empty || probe_last;
  assign rd_addr    = cmd_i.probe_start ? rem_q : idx_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_tomb_q <= 1'b0;
    end else if (cmd_i.probe_start) begin
      have_tomb_q <= 1'b0;
    end else if (cmd_i.probe_run && slot_tomb) begin
      have_tomb_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_start) begin
      probe_idx_q <= rem_q;
      visited_q   <= '0;
    end else if (cmd_i.probe_run && !probe_stop) begin
      probe_idx_q <= idx_next;
      visited_q   <= visited_q + IDX_W'(1);
      if (slot_tomb && !have_tomb_q) begin
        tomb_q <= probe_idx_q;
      end
    end
  end

  // Probe outcome, captured at the slot where the walk stops.
  logic             found_q;
  logic             fresh_q;
  logic             none_q;
  logic [VB-1:0]    hit_value_q;
  logic [IDX_W-1:0] tomb_pos;

  assign tomb_pos = have_tomb_q ? tomb_q : probe_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_run && probe_stop) begin
      found_q     <= slot_match;
      fresh_q     <= !slot_match && slot_empty && !have_tomb_q;
      none_q      <= !slot_match && !slot_empty && !have_tomb_q && !slot_tomb;
      hit_value_q <= kv_rd[VB-1:0];
      if (slot_match || (slot_empty && !have_tomb_q)) begin
        where_q <= probe_idx_q;
      end else begin
        where_q <= tomb_pos;
      end
    end
  end

  // Occupancy count and the limit check for a fresh slot.
  logic [CNT_W-1:0] count_q;
  logic [CNT_W:0]   count_inc;
  logic             set_full;
  logic             set_write;
  logic             del_write;

  assign count_inc = {1'b0, count_q} + (CNT_W + 1)'(1);
  assign set_full  = none_q || (fresh_q && (CMP_W'(count_inc) > CMP_W'(limit_i)));
  assign set_write = cmd_i.commit && (op_q == OP_SET) && !set_full;
  assign del_write = cmd_i.commit && (op_q == OP_DELETE) && found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.sweep_start) begin
      count_q <= '0;
    end else if (set_write && fresh_q) begin
      count_q <= count_inc[CNT_W-1:0];
    end
  end

  // Clearing sweep over the state bits.
  logic [IDX_W-1:0] sweep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_start) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_run) begin
      sweep_q <= (sweep_q == LAST_IDX) ? '0 : sweep_q + IDX_W'(1);
    end
  end

  // Memory write controls.
  always_comb begin
    kv_we      = set_write;
    meta_we    = set_write || del_write || cmd_i.sweep_run;
    meta_waddr = cmd_i.sweep_run ? sweep_q : where_q;
    if (cmd_i.sweep_run) begin
      meta_wdata = META_EMPTY;
    end else if (del_write) begin
      meta_wdata = META_TOMB;
    end else begin
      meta_wdata = META_USED;
    end
  end

  // Pending result register.
  status_e       res_status_q;
  logic [VB-1:0] res_value_q;
  logic          res_new_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.res_sel)
      RES_ABSENT: begin
        res_status_q <= ST_ABSENT;
        res_value_q  <= '0;
        res_new_q    <= 1'b0;
      end
      RES_OK: begin
        res_status_q <= ST_OK;
        res_value_q  <= '0;
        res_new_q    <= 1'b0;
      end
      RES_COMMIT: begin
        case (op_q)
          OP_SET: begin
            res_status_q <= set_full ? ST_FULL : ST_OK;
            res_value_q  <= '0;
            res_new_q    <= !set_full && !found_q;
          end
          OP_GET: begin
            res_status_q <= found_q ? ST_OK : ST_ABSENT;
            res_value_q  <= found_q ? hit_value_q : '0;
            res_new_q    <= 1'b0;
          end
          OP_DELETE: begin
            res_status_q <= found_q ? ST_OK : ST_ABSENT;
            res_value_q  <= '0;
            res_new_q    <= 1'b0;
          end
          default: begin
            res_status_q <= ST_OK;
            res_value_q  <= '0;
            res_new_q    <= 1'b0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Output register: holds a finished result until its transfer.
  logic out_valid_q;
  logic out_free;

  assign out_free = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_status_o <= res_status_q;
      rsp_value_o  <= VALUE_FIELD_W'(res_value_q);
      rsp_new_o    <= res_new_q;
    end
  end

  assign rsp_valid_o = out_valid_q;

  // Status towards the controller.
  always_comb begin
    stat_o.op         = op_q;
    stat_o.count_zero = (count_q == '0);
    stat_o.hash_ready = rem_ready_q;
    stat_o.probe_stop = probe_stop;
    stat_o.sweep_last = (sweep_q == LAST_IDX);
    stat_o.out_free   = out_free;
  end

endmodule : oaht_datapath

`default_nettype wire

FILE: design/oaht_ctrl.sv
// Controller of the hash table: sequences the clearing sweeps (reset and clear), dispatch,
// probe, commit and result hand-off. Depends on oaht_pkg.
`default_nettype none

module oaht_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire oaht_pkg::dp_stat_t  stat_i,
  output oaht_pkg::ctrl_cmd_t      cmd_o
);
  import oaht_pkg::*;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_DISPATCH,
    S_PROBE,
    S_COMMIT,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   sweep_op_q, sweep_op_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    sweep_op_d = sweep_op_q;
    cmd_o      = '0;
    case (state_q)
      S_SWEEP: begin
        cmd_o.sweep_run = 1'b1;
        if (stat_i.sweep_last) begin
          sweep_op_d = 1'b0;
          if (sweep_op_q) begin
            cmd_o.res_sel = RES_OK;
            state_d       = S_FINISH;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.op == OP_CLEAR) begin
          cmd_o.sweep_start = 1'b1;
          sweep_op_d        = 1'b1;
          state_d           = S_SWEEP;
        end else if (stat_i.op != OP_SET && stat_i.count_zero) begin
          cmd_o.res_sel = RES_ABSENT;
          state_d       = S_FINISH;
        end else if (stat_i.hash_ready) begin
          cmd_o.probe_start = 1'b1;
          state_d           = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd_o.probe_run = 1'b1;
        if (stat_i.probe_stop) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit  = 1'b1;
        cmd_o.res_sel = RES_COMMIT;
        state_d       = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register; reset starts with a clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_SWEEP;
      sweep_op_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      sweep_op_q <= sweep_op_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule : oaht_ctrl

`default_nettype wire

FILE: design/oaht_checker.sv
// Port-level checker for the hash table, bound to the top level.
// Depends on oaht_pkg and open_addressing_hash_table_top.
`default_nettype none

module oaht_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_ready_i,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic [1:0]                        status_i,
  input wire logic [oaht_pkg::VALUE_FIELD_W-1:0] value_i,
  input wire logic                              new_i
);
  import oaht_pkg::*;

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
    $stable(value_i) && $stable(new_i))
    else $error("stalled result changed");

  // Only a successful get returns a value; failures carry zero.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> (value_i == '0))
    else $error("failed request returned a value");

  // A new key is only reported by a stored set, which never returns a value.
  a_new_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && new_i |-> (status_i == ST_OK) && (value_i == '0))
    else $error("new key flagged on a failed request");

  // The clearing pass after reset holds off requests.
  a_reset_sweep: assert property (@(posedge clk_i) !rst_ni |=> !in_ready_i)
    else $error("request accepted during the reset clearing pass");

endmodule : oaht_checker

bind open_addressing_hash_table_top oaht_checker u_oaht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .value_i     (rsp_o.value_out),
  .new_i       (rsp_o.key_was_new)
);

`default_nettype wire

FILE: tb/oaht_answer_check.sv
// Response checker for the hash-table testbench: it keeps a shadow copy of the slot table,
// updates it from accepted requests and register writes, checks responses and register reads.
// Depends on oaht_pkg and on the channel interfaces in oaht_if.sv.

module oaht_answer_check import oaht_pkg::*; #(
  parameter int SLOTS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  oaht_req_if                   req_i,
  oaht_rsp_if                   rsp_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int unsigned           mismatches_o,
  output int unsigned           answers_due_o
);

  typedef struct packed {
    status_e                  status;
    logic [VALUE_FIELD_W-1:0] value;
    logic                     was_new;
  } table_answer_t;

  typedef enum logic [1:0] {
    PROBE_HIT,
    PROBE_FREE,
    PROBE_NONE
  } probe_e;

  // Shadow slot table and its occupancy.
  logic [KEY_FIELD_W-1:0]   shadow_key   [SLOTS];
  logic [VALUE_FIELD_W-1:0] shadow_value [SLOTS];
  logic                     shadow_used  [SLOTS];
  logic                     shadow_tomb  [SLOTS];
  logic [8:0]               shadow_count;
  logic [LIMIT_W-1:0]       occ_limit;

  table_answer_t answers_pending [$];

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches_o < 40) begin
      $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    end
    mismatches_o = mismatches_o + 1;
  endtask

  // Linear probe from the hash slot: stops on the key or an empty slot, notes the first
  // tombstone, and gives up after one full lap.
  function automatic probe_e probe_table(logic [KEY_FIELD_W-1:0] key, logic [HASH_W-1:0] hash,
                                         output int unsigned where, output bit fresh);
    int unsigned idx;
    int unsigned tomb_idx;
    bit          have_tomb;
    idx       = hash % SLOTS;
    tomb_idx  = 0;
    have_tomb = 1'b0;
    where     = 0;
    fresh     = 1'b0;
    for (int unsigned n = 0; n < SLOTS; n++) begin
      if (shadow_used[idx]) begin
        if (shadow_key[idx] == key) begin
          where = idx;
          return PROBE_HIT;
        end
      end else if (shadow_tomb[idx]) begin
        if (!have_tomb) begin
          have_tomb = 1'b1;
          tomb_idx  = idx;
        end
      end else begin
        if (have_tomb) begin
          where = tomb_idx;
        end else begin
          where = idx;
          fresh = 1'b1;
        end
        return PROBE_FREE;
      end
      idx = (idx + 1) % SLOTS;
    end
    if (have_tomb) begin
      where = tomb_idx;
      return PROBE_FREE;
    end
    return PROBE_NONE;
  endfunction

  // Applies one request to the shadow table and works out the answer it must produce.
  task automatic predict_table_op(input opcode_e op, input logic [KEY_FIELD_W-1:0] key,
                                  input logic [HASH_W-1:0] hash,
                                  input logic [VALUE_FIELD_W-1:0] val,
                                  output table_answer_t ans);
    int unsigned where;
    bit          fresh;
    probe_e      outcome;
    ans.status  = ST_OK;
    ans.value   = '0;
    ans.was_new = 1'b0;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          shadow_used[i] = 1'b0;
          shadow_tomb[i] = 1'b0;
        end
        shadow_count = '0;
      end
      OP_SET: begin
        outcome = probe_table(key, hash, where, fresh);
        if (outcome == PROBE_NONE ||
            (fresh && ({1'b0, shadow_count} + 10'd1) > {2'b00, occ_limit})) begin
          ans.status = ST_FULL;
        end else begin
          if (outcome == PROBE_FREE) begin
            ans.was_new = 1'b1;
            if (fresh) shadow_count = shadow_count + 9'd1;
          end
          shadow_key[where]   = key;
          shadow_value[where] = val;
          shadow_used[where]  = 1'b1;
          shadow_tomb[where]  = 1'b0;
        end
      end
      default: begin
        // Get and delete: nothing is probed while the count is zero.
        if (shadow_count == '0) begin
          ans.status = ST_ABSENT;
        end else begin
          outcome = probe_table(key, hash, where, fresh);
          if (outcome != PROBE_HIT) begin
            ans.status = ST_ABSENT;
          end else if (op == OP_GET) begin
            ans.value = shadow_value[where];
          end else begin
            shadow_used[where] = 1'b0;
            shadow_tomb[where] = 1'b1;
          end
        end
      end
    endcase
  endtask

  // Watch both channels and the register port at every edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    table_answer_t want;
    table_answer_t fresh_ans;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        shadow_used[i] = 1'b0;
        shadow_tomb[i] = 1'b0;
      end
      shadow_count = '0;
      occ_limit    = LIMIT_W'(192);
      answers_pending.delete();
      mismatches_o  = 0;
      answers_due_o <= 0;
    end else begin
      // A response transfer always belongs to an earlier request, so it is matched first.
      if (rsp_i.valid && rsp_i.ready) begin
        if (answers_pending.size() == 0) begin
          report_mismatch("response with nothing outstanding", 64'(rsp_i.status), 64'hx);
        end else begin
          want = answers_pending.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch("status", 64'(rsp_i.status), 64'(want.status));
          if (rsp_i.value_out !== want.value)
            report_mismatch("value_out", rsp_i.value_out, want.value);
          if (rsp_i.key_was_new !== want.was_new)
            report_mismatch("key_was_new", 64'(rsp_i.key_was_new), 64'(want.was_new));
        end
      end
      if (req_i.valid && req_i.ready) begin
        predict_table_op(opcode_e'(req_i.opcode), req_i.key_id, req_i.key_hash,
                         req_i.value_in, fresh_ans);
        answers_pending.push_back(fresh_ans);
      end
      // Register port: writes update the limit, reads must return it zero-extended.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_OCC_LIMIT) occ_limit = pwdata[LIMIT_W-1:0];
        end else if (prdata !== {{(APB_DATA_W-LIMIT_W){1'b0}}, occ_limit}) begin
          report_mismatch("occupancy_limit read", 64'(prdata), 64'(occ_limit));
        end
      end
      answers_due_o <= answers_pending.size();
    end
  end

endmodule : oaht_answer_check

FILE: tb/testbench.sv
// Top of the hash-table testbench: clock, reset, request and register stimulus, the ready
// pattern of the response side, a stall watchdog and the verdict.
// Depends on oaht_pkg, oaht_if.sv, the table RTL and tb/oaht_answer_check.sv.

module testbench;
  import oaht_pkg::*;

  localparam int SLOTS       = 256;
  localparam int POOL        = 32;
  localparam int STALL_LIMIT = 3000;
  localparam logic [APB_ADDR_W-1:0] ADDR_OCC_LIMIT = {REG_OCC_LIMIT, 2'b00};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned mismatches;
  int unsigned answers_due;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles = 0;
  bit          long_hold_req;

  logic [KEY_FIELD_W-1:0] pool_key  [POOL];
  logic [HASH_W-1:0]      pool_hash [POOL];
  logic [KEY_FIELD_W-1:0] fill_key  [SLOTS];
  logic [HASH_W-1:0]      fill_hash [SLOTS];

  oaht_req_if req_if();
  oaht_rsp_if rsp_if();

  open_addressing_hash_table_top #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (32),
    .VALUE_BITS (64)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  oaht_answer_check #(.SLOTS(SLOTS)) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatches_o  (mismatches),
    .answers_due_o (answers_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Response side: random ready, plus one long hold-off once the stimulus asks for it.
  initial begin : response_ready
    int unsigned hold_left;
    bit          hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 150;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when no transfer has happened for too long.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request, with random idle cycles before it, and returns at its transfer edge.
  task automatic send_req(opcode_e op, logic [KEY_FIELD_W-1:0] key, logic [HASH_W-1:0] hash,
                          logic [VALUE_FIELD_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.opcode   <= op;
    req_if.key_id   <= key;
    req_if.key_hash <= hash;
    req_if.value_in <= val;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // One register access: setup cycle, then access cycle until pready.
  task automatic apb_access(bit write, logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops offering requests and waits until every answer has come back.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (answers_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limit(int unsigned limit);
    wait_idle();
    apb_access(1'b1, ADDR_OCC_LIMIT, APB_DATA_W'(limit));
    apb_access(1'b0, ADDR_OCC_LIMIT, '0);
  endtask

  // Hand-picked sequence: empty table, collisions, wrap, replace, tombstones, clear.
  task automatic run_directed();
    send_req(OP_GET,    32'h1234_5678, 32'h0000_0000, 64'h0);
    send_req(OP_DELETE, 32'h1234_5678, 32'h0000_0000, '1);
    send_req(OP_SET,    32'h0000_0000, 32'h0000_0000, '1);
    send_req(OP_SET,    32'hFFFF_FFFF, 32'hFFFF_FF00, 64'h0);
    send_req(OP_SET,    32'hA5A5_5A5A, 32'hFFFF_FFFF, 64'h8000_0000_0000_0001);
    // Starts at the last slot and wraps round past the two taken at the bottom.
    send_req(OP_SET,    32'h5A5A_A5A5, 32'h0000_00FF, 64'h7FFF_FFFF_FFFF_FFFE);
    send_req(OP_GET,    32'h5A5A_A5A5, 32'h0000_00FF, 64'h0);
    send_req(OP_SET,    32'h0000_0000, 32'h0000_0000, 64'h0123_4567_89AB_CDEF);
    send_req(OP_GET,    32'h0000_0000, 32'h0000_0000, '1);
    send_req(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FF00, 64'h0);
    send_req(OP_GET,    32'h5A5A_A5A5, 32'h0000_00FF, 64'h0);
    send_req(OP_GET,    32'hFFFF_FFFF, 32'hFFFF_FF00, 64'h0);
    send_req(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FF00, 64'h0);
    // New key on the same path takes the tombstone left above.
    send_req(OP_SET,    32'hC3C3_3C3C, 32'h0000_0100, 64'hFEDC_BA98_7654_3210);
    send_req(OP_GET,    32'hC3C3_3C3C, 32'h8000_0000, 64'h0);
    send_req(OP_GET,    32'hC3C3_3C3C, 32'h0000_0003, 64'h0);
    send_req(OP_GET,    32'h0BAD_F00D, 32'h0000_0000, 64'h0);
    send_req(OP_CLEAR,  32'h0000_0000, 32'h0000_0000, 64'h0);
    send_req(OP_GET,    32'h0000_0000, 32'h0000_0000, 64'h0);
    send_req(OP_CLEAR,  '1, '1, '1);
  endtask

  // Limit of zero and of one: refusals, replacement and tombstone reuse at the limit.
  task automatic run_limit_edges();
    set_limit(0);
    send_req(OP_SET,    32'h0000_1111, 32'h0000_0010, 64'h11);
    send_req(OP_GET,    32'h0000_1111, 32'h0000_0010, 64'h0);
    set_limit(1);
    send_req(OP_SET,    32'h0000_1111, 32'h0000_0010, 64'h11);
    send_req(OP_SET,    32'h0000_2222, 32'h0000_0020, 64'h22);
    send_req(OP_SET,    32'h0000_1111, 32'h0000_0010, 64'h33);
    send_req(OP_GET,    32'h0000_1111, 32'h0000_0010, 64'h0);
    send_req(OP_DELETE, 32'h0000_1111, 32'h0000_0010, 64'h0);
    send_req(OP_SET,    32'h0000_2222, 32'h0000_0010, 64'h44);
    send_req(OP_SET,    32'h0000_3333, 32'h0000_0030, 64'h55);
    send_req(OP_CLEAR,  32'h0000_0000, 32'h0000_0000, 64'h0);
  endtask

  // Fills the table to the highest limit, then probes, deletes and reuses tombstones.
  task automatic run_fill();
    int unsigned j;
    set_limit(255);
    for (int i = 0; i < 255; i++) begin
      fill_key[i]  = {8'(i), 24'($urandom)};
      fill_hash[i] = $urandom;
      send_req(OP_SET, fill_key[i], fill_hash[i], {$urandom, $urandom});
    end
    send_req(OP_SET, {8'hFF, 24'($urandom)}, $urandom, {$urandom, $urandom});
    for (int i = 0; i < 8; i++) begin
      j = $urandom_range(254);
      send_req(OP_GET, fill_key[j], fill_hash[j], 64'h0);
    end
    for (int i = 0; i < 6; i++) begin
      j = (i * 37) % 255;
      send_req(OP_DELETE, fill_key[j], fill_hash[j], 64'h0);
    end
    for (int i = 0; i < 6; i++) begin
      send_req(OP_SET, {8'hFF, 24'($urandom)}, $urandom, {$urandom, $urandom});
    end
    send_req(OP_GET, {8'hFF, 24'($urandom)}, $urandom, 64'h0);
    send_req(OP_CLEAR, 32'h0, 32'h0, 64'h0);
  endtask

  // Random traffic over a small pool of keys whose hashes cluster, so that probes collide.
  task automatic run_traffic(int unsigned count, int unsigned limit, bit hold);
    int unsigned             roll;
    int unsigned             pick;
    int unsigned             cluster;
    opcode_e                 op;
    logic [KEY_FIELD_W-1:0]  key;
    logic [HASH_W-1:0]       hash;
    set_limit(limit);
    cluster = $urandom_range(255);
    for (int i = 0; i < POOL; i++) begin
      pool_key[i]  = $urandom;
      pool_hash[i] = {24'($urandom), 8'(cluster + $urandom_range(23))};
    end
    send_req(OP_CLEAR, 32'h0, 32'h0, 64'h0);
    if (hold) long_hold_req = 1'b1;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      pick = $urandom_range(POOL - 1);
      key  = pool_key[pick];
      hash = pool_hash[pick];
      if (roll < 5) begin
        op   = opcode_e'($urandom_range(3));
        key  = $urandom;
        hash = $urandom;
      end else if (roll < 7) begin
        op = OP_CLEAR;
      end else if (roll < 47) begin
        op = OP_SET;
      end else if (roll < 77) begin
        op = OP_GET;
      end else begin
        op = OP_DELETE;
      end
      // Now and then a known key arrives with a stray hash.
      if ($urandom_range(19) == 0) hash = $urandom;
      send_req(op, key, hash, {$urandom, $urandom});
    end
  endtask

  initial begin : stimulus
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.opcode   = OP_GET;
    req_if.key_id   = '0;
    req_if.key_hash = '0;
    req_if.value_in = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    long_hold_req   = 1'b0;
    send_idle_pct   = 12;
    recv_idle_pct   = 54;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of the limit, then the hand-picked cases.
    apb_access(1'b0, ADDR_OCC_LIMIT, '0);
    run_directed();
    run_limit_edges();
    run_fill();
    run_traffic(140, 24, 1'b0);

    send_idle_pct = 54;
    recv_idle_pct = 12;
    run_traffic(140, 255, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_traffic(140, $urandom_range(2, 254), 1'b0);
    // Response side holds off while requests keep coming, so the input backs up.
    run_traffic(30, 200, 1'b1);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && answers_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule : testbench

FILE: files.f
design/oaht_pkg.sv
design/oaht_if.sv
design/oaht_ram.sv
design/oaht_datapath.sv
design/oaht_ctrl.sv
design/open_addressing_hash_table_top.sv
design/oaht_checker.sv
tb/oaht_answer_check.sv
tb/testbench.sv
